/* hw/rtl/bpc_pkg.sv */
// Shared types, constants and helper functions for the pressure compensation block.
// No dependencies; every other file but bpc_div refers to it by scoped names.
package bpc_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_DIV,
        ST_DONE
    } state_t;

    // Datapath operations, in the order they are sequenced
    typedef enum logic [4:0] {
        OP_T_X1,
        OP_T_DIV,
        OP_T_FIN,
        OP_P_SQ,
        OP_P_X1,
        OP_P_X2,
        OP_P_B3,
        OP_P_X1B,
        OP_P_X2B,
        OP_P_X3,
        OP_P_B4,
        OP_P_B7,
        OP_P_DIV,
        OP_P_P,
        OP_P_SQP,
        OP_P_C1,
        OP_P_C2,
        OP_P_FIN
    } op_t;

    typedef enum logic [1:0] {
        REG_CAL_A,
        REG_CAL_B,
        REG_CAL_C,
        REG_OSS
    } reg_idx_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic emit;
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic div_zero;
        logic div_done;
        logic out_free;
    } sts_t;

    localparam logic [31:0] C_B6_OFS    = 32'd4000;
    localparam logic [31:0] C_B4_OFS    = 32'd32768;
    localparam logic [31:0] C_B7_SCALE  = 32'd50000;
    localparam logic [31:0] C_P_MUL1    = 32'd3038;
    localparam logic [31:0] C_P_MUL2    = 32'hFFFF_E343;
    localparam logic [31:0] C_P_ADD     = 32'd3791;
    localparam logic [31:0] C_MSB       = 32'h8000_0000;
    localparam logic [1:0]  C_OSS_RESET = 2'd3;

    function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
        asr32 = $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] zx16(input logic [15:0] v);
        zx16 = {16'd0, v};
    endfunction

endpackage

/* hw/rtl/bpc_div.sv */
// Unsigned 32 by 32 restoring divider, one quotient bit per cycle.
// Stand-alone; used by bpc_datapath.
module bpc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [31:0] quo
);

    logic        busy_reg, busy_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] den_reg, den_next;
    logic        done_reg, done_next;
    logic [32:0] trial;
    logic [32:0] diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[31]};
        diff      = trial - {1'b0, den_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            rem_next  = 32'd0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (!diff[32])
            begin
                rem_next = diff[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* hw/rtl/bpc_datapath.sv */
// Datapath: operand registers, one shared multiplier, divider and output beat register.
// Depends on bpc_pkg and bpc_div.
module bpc_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  bpc_pkg::cmd_t      cmd,
    output bpc_pkg::sts_t      sts,
    input  logic               func,
    input  logic [18:0]        raw_value,
    input  logic [63:0]        cal_a,
    input  logic [63:0]        cal_b,
    input  logic [31:0]        cal_c,
    input  logic [1:0]         oss,
    input  logic               out_stall,
    output logic               out_valid,
    output logic [31:0]        value,
    output logic               kind,
    output logic               error
);

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic        func_reg;
    logic [18:0] raw_reg;
    logic [31:0] term_reg, term_next;
    logic [31:0] x1_reg, x1_next, x2_reg, x2_next, sq_reg, sq_next;
    logic [31:0] b6_reg, b6_next, b3_reg, b3_next, b4_reg, b4_next;
    logic [31:0] b7_reg, b7_next, p_reg, p_next, res_reg, res_next;
    logic        err_reg, err_next, neg_reg, neg_next;
    logic        out_valid_reg;
    logic [31:0] value_reg;
    logic        kind_reg, error_reg;
    logic [31:0] mul_a, mul_b, prod, raw32, b6c, tden, tnum, qsig, sum, b3_sum, psh;
    logic        div_start, div_done;
    logic [31:0] div_num, div_den, div_q;

    assign ac1 = bpc_pkg::sx16(cal_a[63:48]);
    assign ac2 = bpc_pkg::sx16(cal_a[47:32]);
    assign ac3 = bpc_pkg::sx16(cal_a[31:16]);
    assign ac4 = bpc_pkg::zx16(cal_a[15:0]);
    assign ac5 = bpc_pkg::zx16(cal_b[63:48]);
    assign ac6 = bpc_pkg::zx16(cal_b[47:32]);
    assign b1  = bpc_pkg::sx16(cal_b[31:16]);
    assign b2  = bpc_pkg::sx16(cal_b[15:0]);
    assign mc  = bpc_pkg::sx16(cal_c[31:16]);
    assign md  = bpc_pkg::sx16(cal_c[15:0]);

    assign raw32 = {13'd0, raw_reg};
    assign b6c   = term_reg - bpc_pkg::C_B6_OFS;
    assign tden  = x1_reg + md;
    assign tnum  = {mc[20:0], 11'd0};
    assign psh   = bpc_pkg::asr32(p_reg, 5'd8);

    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        case (cmd.op)
            bpc_pkg::OP_T_X1:  begin mul_a = raw32 - ac6; mul_b = ac5; end
            bpc_pkg::OP_P_SQ:  begin mul_a = b6c; mul_b = b6c; end
            bpc_pkg::OP_P_X1:  begin mul_a = b2; mul_b = sq_reg; end
            bpc_pkg::OP_P_X2:  begin mul_a = ac2; mul_b = b6_reg; end
            bpc_pkg::OP_P_X1B: begin mul_a = ac3; mul_b = b6_reg; end
            bpc_pkg::OP_P_X2B: begin mul_a = b1; mul_b = sq_reg; end
            bpc_pkg::OP_P_B4:  begin mul_a = ac4; mul_b = x1_reg + bpc_pkg::C_B4_OFS; end
            bpc_pkg::OP_P_B7:  begin mul_a = raw32 - b3_reg; mul_b = bpc_pkg::C_B7_SCALE >> oss; end
            bpc_pkg::OP_P_SQP: begin mul_a = psh; mul_b = psh; end
            bpc_pkg::OP_P_C1:  begin mul_a = x1_reg; mul_b = bpc_pkg::C_P_MUL1; end
            bpc_pkg::OP_P_C2:  begin mul_a = bpc_pkg::C_P_MUL2; mul_b = p_reg; end
            default:           begin mul_a = 32'd0; mul_b = 32'd0; end
        endcase
    end

    assign prod = mul_a * mul_b;

    assign sts.div_zero = (cmd.op == bpc_pkg::OP_T_DIV) ? (tden == 32'd0) : (b4_reg == 32'd0);
    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        term_next = term_reg;
        x1_next   = x1_reg;
        x2_next   = x2_reg;
        sq_next   = sq_reg;
        b6_next   = b6_reg;
        b3_next   = b3_reg;
        b4_next   = b4_reg;
        b7_next   = b7_reg;
        p_next    = p_reg;
        res_next  = res_reg;
        err_next  = err_reg;
        neg_next  = neg_reg;
        div_start = 1'b0;
        div_num   = 32'd0;
        div_den   = 32'd0;
        qsig      = neg_reg ? (32'd0 - div_q) : div_q;
        sum       = x1_reg + qsig;
        b3_sum    = {ac1[29:0], 2'd0} + x1_reg + x2_reg;
        if (cmd.load)
        begin
            err_next = 1'b0;
            res_next = 32'd0;
        end
        else if (cmd.exec)
        begin
            case (cmd.op)
                bpc_pkg::OP_T_X1:  x1_next = bpc_pkg::asr32(prod, 5'd15);
                bpc_pkg::OP_T_DIV:
                begin
                    if (tden == 32'd0)
                    begin
                        err_next = 1'b1;
                        res_next = 32'd0;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        div_num   = tnum[31] ? (32'd0 - tnum) : tnum;
                        div_den   = tden[31] ? (32'd0 - tden) : tden;
                        neg_next  = tnum[31] ^ tden[31];
                    end
                end
                bpc_pkg::OP_T_FIN:
                begin
                    term_next = sum;
                    res_next  = bpc_pkg::asr32(sum + 32'd8, 5'd4);
                end
                bpc_pkg::OP_P_SQ:
                begin
                    b6_next = b6c;
                    sq_next = bpc_pkg::asr32(prod, 5'd12);
                end
                bpc_pkg::OP_P_X1:  x1_next = bpc_pkg::asr32(prod, 5'd11);
                bpc_pkg::OP_P_X2:  x2_next = bpc_pkg::asr32(prod, 5'd11);
                bpc_pkg::OP_P_B3:
                    b3_next = bpc_pkg::asr32((b3_sum << oss) + 32'd2, 5'd2);
                bpc_pkg::OP_P_X1B: x1_next = bpc_pkg::asr32(prod, 5'd13);
                bpc_pkg::OP_P_X2B: x2_next = bpc_pkg::asr32(prod, 5'd16);
                bpc_pkg::OP_P_X3:  x1_next = bpc_pkg::asr32(x1_reg + x2_reg + 32'd2, 5'd2);
                bpc_pkg::OP_P_B4:  b4_next = prod >> 15;
                bpc_pkg::OP_P_B7:  b7_next = prod;
                bpc_pkg::OP_P_DIV:
                begin
                    if (b4_reg == 32'd0)
                    begin
                        err_next = 1'b1;
                        res_next = 32'd0;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        div_num   = b7_reg[31] ? b7_reg : {b7_reg[30:0], 1'b0};
                        div_den   = b4_reg;
                    end
                end
                bpc_pkg::OP_P_P:
                    p_next = b7_reg[31] ? {div_q[30:0], 1'b0} : div_q;
                bpc_pkg::OP_P_SQP: x1_next = prod;
                bpc_pkg::OP_P_C1:  x1_next = bpc_pkg::asr32(prod, 5'd16);
                bpc_pkg::OP_P_C2:  x2_next = bpc_pkg::asr32(prod, 5'd16);
                bpc_pkg::OP_P_FIN:
                    res_next = p_reg
                             + bpc_pkg::asr32(x1_reg + x2_reg + bpc_pkg::C_P_ADD, 5'd4);
                default: res_next = res_reg;
            endcase
        end
    end

    bpc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_reg      <= 32'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            term_reg <= term_next;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            raw_reg  <= raw_value;
        end
        x1_reg  <= x1_next;
        x2_reg  <= x2_next;
        sq_reg  <= sq_next;
        b6_reg  <= b6_next;
        b3_reg  <= b3_next;
        b4_reg  <= b4_next;
        b7_reg  <= b7_next;
        p_reg   <= p_next;
        res_reg <= res_next;
        err_reg <= err_next;
        neg_reg <= neg_next;
        if (cmd.emit)
        begin
            value_reg <= res_reg;
            kind_reg  <= func_reg;
            error_reg <= err_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign kind      = kind_reg;
    assign error     = error_reg;

endmodule

/* hw/rtl/bpc_ctrl.sv */
// Controller: sequences datapath operations for one item at a time.
// Depends on bpc_pkg.
module bpc_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          func,
    output bpc_pkg::cmd_t cmd,
    input  bpc_pkg::sts_t sts
);

    bpc_pkg::state_t state_reg, state_next;
    bpc_pkg::op_t    op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpc_pkg::ST_IDLE;
            op_reg    <= bpc_pkg::OP_T_X1;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        in_stall   = 1'b1;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        cmd.emit   = 1'b0;
        cmd.op     = op_reg;
        case (state_reg)
            bpc_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    op_next    = func ? bpc_pkg::OP_P_SQ : bpc_pkg::OP_T_X1;
                    state_next = bpc_pkg::ST_STEP;
                end
            end
            bpc_pkg::ST_STEP:
            begin
                cmd.exec = 1'b1;
                if (op_reg == bpc_pkg::OP_T_FIN || op_reg == bpc_pkg::OP_P_FIN)
                    state_next = bpc_pkg::ST_DONE;
                else if (op_reg == bpc_pkg::OP_T_DIV || op_reg == bpc_pkg::OP_P_DIV)
                begin
                    // zero divisor: skip straight to the result beat
                    if (sts.div_zero)
                        state_next = bpc_pkg::ST_DONE;
                    else
                    begin
                        op_next    = bpc_pkg::op_t'(op_reg + 5'd1);
                        state_next = bpc_pkg::ST_DIV;
                    end
                end
                else
                    op_next = bpc_pkg::op_t'(op_reg + 5'd1);
            end
            bpc_pkg::ST_DIV:
            begin
                if (sts.div_done)
                    state_next = bpc_pkg::ST_STEP;
            end
            bpc_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = bpc_pkg::ST_IDLE;
                end
            end
            default: state_next = bpc_pkg::ST_IDLE;
        endcase
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result beat issued while output register busy");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sts.div_done |-> state_reg == bpc_pkg::ST_DIV)
        else $error("divider finished outside the wait state");

    a_accept_run: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == bpc_pkg::ST_STEP)
        else $error("accepted beat did not start a sequence");

endmodule

/* hw/rtl/barometric_pressure_compensation.sv */
// Barometric pressure compensation. Each input beat carries a raw temperature or
// pressure reading; one result beat follows. Items are processed one at a time.
// Each kind waits once on the bit-serial divider; its other steps run one at a time
// and share one 32x32 multiplier. The next beat is accepted once the result beat has
// been loaded. A zero divisor ends the item early with error set. Calibration is
// written over the APB port at 8-byte spacing; the user must write it only while
// idle, as the block itself does not enforce this.
module barometric_pressure_compensation (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [18:0] raw_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] value,
    output logic        kind,
    output logic        error,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    logic [63:0]        cal_a_reg, cal_b_reg;
    logic [31:0]        cal_c_reg;
    logic [1:0]         oss_reg;
    logic               wr_en;
    bpc_pkg::reg_idx_t  ridx;
    bpc_pkg::cmd_t      cmd;
    bpc_pkg::sts_t      sts;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign ridx   = bpc_pkg::reg_idx_t'(paddr[4:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_a_reg <= 64'd0;
            cal_b_reg <= 64'd0;
            cal_c_reg <= 32'd0;
            oss_reg   <= bpc_pkg::C_OSS_RESET;
        end
        else if (wr_en)
        begin
            case (ridx)
                bpc_pkg::REG_CAL_A: cal_a_reg <= pwdata;
                bpc_pkg::REG_CAL_B: cal_b_reg <= pwdata;
                bpc_pkg::REG_CAL_C: cal_c_reg <= pwdata[31:0];
                bpc_pkg::REG_OSS:   oss_reg   <= pwdata[1:0];
                default:            oss_reg   <= oss_reg;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            bpc_pkg::REG_CAL_A: prdata = cal_a_reg;
            bpc_pkg::REG_CAL_B: prdata = cal_b_reg;
            bpc_pkg::REG_CAL_C: prdata = {32'd0, cal_c_reg};
            bpc_pkg::REG_OSS:   prdata = {62'd0, oss_reg};
            default:            prdata = 64'd0;
        endcase
    end

    bpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .cmd      (cmd),
        .sts      (sts)
    );

    bpc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .func      (func),
        .raw_value (raw_value),
        .cal_a     (cal_a_reg),
        .cal_b     (cal_b_reg),
        .cal_c     (cal_c_reg),
        .oss       (oss_reg),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .value     (value),
        .kind      (kind),
        .error     (error)
    );

endmodule

/* dv/tb_barometric_pressure_compensation.sv */
// Testbench for the barometric pressure compensation block: directed and random
// readings, calibration written over APB, results checked against an in-bench predictor.
// Depends on bpc_pkg and barometric_pressure_compensation.
`timescale 1ns / 100ps

module tb_barometric_pressure_compensation;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        func = 1'b0;
    logic [18:0] raw_value = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] value;
    logic        kind;
    logic        error;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    typedef struct packed {
        logic [31:0] value;
        logic        kind;
        logic        error;
    } reading_t;

    reading_t    expected_q[$];
    logic [63:0] cal_a;
    logic [63:0] cal_b;
    logic [31:0] cal_c;
    logic [1:0]  oss;
    logic [31:0] temp_term;
    int          mismatches = 0;
    bit          long_stalls = 1'b0;

    barometric_pressure_compensation u_top (.*);

    always #10 clk = ~clk;

    function automatic logic [31:0] sra(input logic [31:0] x, input int n);
        return $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [31:0] ext16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // Compute the compensated reading and update the kept temperature term.
    function automatic reading_t compensate(input logic f, input logic [18:0] raw);
        reading_t r;
        logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, up;
        logic [31:0] x1, x2, x3, d, n, q, b6, sq, b3, b4, b7, p;
        ac1 = ext16(cal_a[63:48]); ac2 = ext16(cal_a[47:32]);
        ac3 = ext16(cal_a[31:16]); ac4 = {16'd0, cal_a[15:0]};
        ac5 = {16'd0, cal_b[63:48]}; ac6 = {16'd0, cal_b[47:32]};
        b1 = ext16(cal_b[31:16]); b2 = ext16(cal_b[15:0]);
        mc = ext16(cal_c[31:16]); md = ext16(cal_c[15:0]);
        up = {13'd0, raw};
        r = '0;
        r.kind = f;
        if (!f) begin
            x1 = sra((up - ac6) * ac5, 15);
            d = x1 + md;
            if (d == 0) r.error = 1'b1;
            else begin
                n = mc << 11;
                q = (n[31] ? -n : n) / (d[31] ? -d : d);
                x2 = (n[31] != d[31]) ? -q : q;
                temp_term = x1 + x2;
                r.value = sra(temp_term + 32'd8, 4);
            end
        end else begin
            b6 = temp_term - 32'd4000;
            sq = sra(b6 * b6, 12);
            x1 = sra(b2 * sq, 11);
            x2 = sra(ac2 * b6, 11);
            b3 = sra(((ac1 * 32'd4 + x1 + x2) << oss) + 32'd2, 2);
            x1 = sra(ac3 * b6, 13);
            x2 = sra(b1 * sq, 16);
            x3 = sra(x1 + x2 + 32'd2, 2);
            b4 = (ac4 * (x3 + 32'd32768)) >> 15;
            b7 = (up - b3) * (32'd50000 >> oss);
            if (b4 == 0) r.error = 1'b1;
            else begin
                p = b7[31] ? (b7 / b4) << 1 : (b7 << 1) / b4;
                x1 = sra(p, 8);
                x1 = x1 * x1;
                x1 = sra(x1 * 32'd3038, 16);
                x2 = sra(-32'd7357 * p, 16);
                r.value = p + sra(x1 + x2 + 32'd3791, 4);
            end
        end
        return r;
    endfunction

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_reading(input logic f, input logic [18:0] raw);
        int g;
        g = gap_len();
        // valid was dropped at the last edge; wait out a random gap from gap_len before raising it
        repeat (g + 1) @(posedge clk);
        in_valid <= 1'b1;
        func <= f;
        raw_value <= raw;
        expected_q.push_back(compensate(f, raw));
        @(posedge clk);
        while (in_stall) @(posedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (expected_q.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(input bpc_pkg::reg_idx_t idx, input logic [63:0] data);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(idx) << 3; pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            bpc_pkg::REG_CAL_A: cal_a = data;
            bpc_pkg::REG_CAL_B: cal_b = data;
            bpc_pkg::REG_CAL_C: cal_c = data[31:0];
            default:            oss = data[1:0];
        endcase
        @(posedge clk);
    endtask

    // Typical datasheet-like calibration, randomized slightly.
    task automatic load_typical_cal(input logic [1:0] o);
        write_reg(bpc_pkg::REG_CAL_A,
                  {16'd408, 16'hFFCA, 16'hC1C4, 16'd32741 + 16'($urandom_range(0, 40))});
        write_reg(bpc_pkg::REG_CAL_B, {16'd32757, 16'd23153, 16'd6190, 16'd4});
        write_reg(bpc_pkg::REG_CAL_C, 64'({16'h8000 - 16'd8711 + 16'h8000, 16'd2868}));
        write_reg(bpc_pkg::REG_OSS, 64'(o));
    endtask

    task automatic test_reset_defaults();
        send_reading(1'b1, 19'd0);
        send_reading(1'b0, 19'h7FFFF);
        send_reading(1'b1, 19'h7FFFF);
        drain();
    endtask

    task automatic test_directed();
        load_typical_cal(2'd0);
        send_reading(1'b0, 19'd27898);
        send_reading(1'b1, 19'd23843);
        send_reading(1'b0, 19'd0);
        send_reading(1'b1, 19'd0);
        send_reading(1'b0, 19'h7FFFF);
        send_reading(1'b1, 19'h7FFFF);
        drain();
        // zero temperature divisor: ac5 of zero makes x1 zero, and md is zero
        write_reg(bpc_pkg::REG_CAL_C, 64'({16'd5, 16'd0}));
        write_reg(bpc_pkg::REG_CAL_B, {16'd0, 16'd100, 16'd0, 16'd0});
        send_reading(1'b0, 19'd100);
        send_reading(1'b1, 19'd500);
        drain();
        // zero pressure divisor: ac4 of zero
        write_reg(bpc_pkg::REG_CAL_A, {16'h7FFF, 16'h8000, 16'h7FFF, 16'd0});
        write_reg(bpc_pkg::REG_OSS, 64'd3);
        send_reading(1'b1, 19'd1234);
        drain();
        // negative sums and extreme calibration
        write_reg(bpc_pkg::REG_CAL_A, {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF});
        write_reg(bpc_pkg::REG_CAL_B, {16'hFFFF, 16'hFFFF, 16'h8000, 16'h7FFF});
        write_reg(bpc_pkg::REG_CAL_C, 64'({16'h7FFF, 16'h8000}));
        send_reading(1'b0, 19'd0);
        send_reading(1'b1, 19'h7FFFF);
        send_reading(1'b0, 19'h7FFFF);
        send_reading(1'b1, 19'd0);
        drain();
        write_reg(bpc_pkg::REG_CAL_C, 64'(32'hFFFF_FFFF));
        send_reading(1'b0, 19'h55555);
        send_reading(1'b1, 19'h2AAAA);
        drain();
    endtask

    task automatic test_random(input int n, input bit typical);
        logic [1:0] o;
        o = 2'($urandom_range(0, 3));
        if (typical) load_typical_cal(o);
        else begin
            write_reg(bpc_pkg::REG_CAL_A, {$urandom, $urandom});
            write_reg(bpc_pkg::REG_CAL_B, {$urandom, $urandom});
            write_reg(bpc_pkg::REG_CAL_C, 64'($urandom));
            write_reg(bpc_pkg::REG_OSS, 64'(o));
        end
        for (int i = 0; i < n; i++) begin
            if (typical && $urandom_range(0, 9) != 0)
                send_reading(1'($urandom_range(0, 1)),
                             19'($urandom_range(15000, 35000) + ($urandom_range(0, 1) ? 0 : 5000)));
            else
                send_reading(1'($urandom_range(0, 1)), 19'($urandom));
        end
        drain();
    endtask

    task automatic test_paced();
        long_stalls = 1'b1;
        for (int i = 0; i < 30; i++) begin
            send_reading(1'($urandom_range(0, 1)), 19'($urandom));
            if (i % 10 == 0)
                while (expected_q.size() != 0) @(posedge clk);
        end
        drain();
        long_stalls = 1'b0;
    endtask

    // Randomize the result-side stall; stretches with no stall too.
    always @(posedge clk) begin
        if (long_stalls || $urandom_range(0, 9) < 3) out_stall <= ($urandom_range(0, 2) == 0);
        else out_stall <= 1'b0;
    end

    always @(posedge clk) begin
        reading_t got, want;
        if (rst_n && out_valid && !out_stall) begin
            got = '{value: value, kind: kind, error: error};
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat: %h", got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp value %h kind %b error %b, got %h %b %b",
                                 want.value, want.kind, want.error,
                                 got.value, got.kind, got.error);
                end
            end
        end
    end

    initial begin
        cal_a = '0; cal_b = '0; cal_c = '0; oss = bpc_pkg::C_OSS_RESET; temp_term = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed();
        test_random(300, 1'b1);
        test_random(200, 1'b0);
        test_paced();
        test_random(250, 1'b1);
        test_random(150, 1'b0);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

/* filelist.f */
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_div.sv
hw/rtl/bpc_datapath.sv
hw/rtl/bpc_ctrl.sv
hw/rtl/barometric_pressure_compensation.sv
dv/tb_barometric_pressure_compensation.sv
